/* sv/pat_pkg.sv */
// ----------------------------------------------------------------------------
// pat_pkg
// shared types, constants and constant functions of the altitude trend core
// ----------------------------------------------------------------------------
package pat_pkg;

	localparam int LOG_FRAC_W = 24;
	localparam int LOG_W      = 29;
	localparam int ITER_W     = 5;
	localparam int MUL_A_W    = 36;
	localparam int MUL_B_W    = 31;
	localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
	localparam int ROOT_W     = 31;

	localparam logic [27:0] EXP_K     = 28'd204322332;
	localparam logic [15:0] ALT_SCALE = 16'd44330;

	localparam logic [16:0]        SLP_RESET = 17'd101325;
	localparam logic [14:0]        TMC_RESET = 15'd20;
	localparam logic signed [15:0] OMC_RESET = 16'sd10;

	typedef enum logic [1:0] {
		REG_SLP = 2'd0,
		REG_TMC = 2'd1,
		REG_OMC = 2'd2,
		REG_NONE = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIR_STATIC = 2'd0,
		DIR_ASC    = 2'd1,
		DIR_DESC   = 2'd2,
		DIR_BAD    = 2'd3
	} dir_t;

	typedef struct packed {
		logic               start;
		logic signed [17:0] pressure;
		logic [16:0]        sea_level;
	} baro_req_t;

	typedef struct packed {
		logic               done;
		logic signed [17:0] altitude;
	} baro_rsp_t;

	// integer square root, bit pair at a time
	function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = x_in;
		r = '0;
		b = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (b > x) b = b >> 2;
		end
		for (int k = 0; k < 32; k++) begin
			if (b != 64'd0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// 2^(2^-i) in q1.30 for i = 1..24, entry i-1 in the lowest slot first
	function automatic logic [LOG_FRAC_W*ROOT_W-1:0] root_table();
		logic [LOG_FRAC_W*ROOT_W-1:0] t;
		logic [63:0] r;
		t = '0;
		r = 64'd1 << 31;
		for (int i = 0; i < LOG_FRAC_W; i++) begin
			r = isqrt64(r << 30);
			t[i*ROOT_W +: ROOT_W] = r[ROOT_W-1:0];
		end
		return t;
	endfunction

endpackage

/* sv/pat_mul.sv */
// ----------------------------------------------------------------------------
// pat_mul
// shared unsigned multiplier used by the log2, exponent, root and scale steps of the altitude sequencer
// ----------------------------------------------------------------------------
module pat_mul (
	input  logic [pat_pkg::MUL_A_W-1:0] a,
	input  logic [pat_pkg::MUL_B_W-1:0] b,
	output logic [pat_pkg::MUL_P_W-1:0] p
);
	import pat_pkg::*;

	assign p = MUL_P_W'(a) * MUL_P_W'(b);

endmodule

/* sv/pat_baro.sv */
// ----------------------------------------------------------------------------
// pat_baro
// sequencer turning a pressure into an altitude through log2, power and exp2
// ----------------------------------------------------------------------------
module pat_baro (
	input  logic              clk,
	input  logic              arst_n,
	input  pat_pkg::baro_req_t req,
	output pat_pkg::baro_rsp_t rsp
);
	import pat_pkg::*;

	localparam logic [LOG_FRAC_W*ROOT_W-1:0] ROOTS = root_table();
	localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(LOG_FRAC_W - 1);

	typedef enum logic [2:0] {
		B_IDLE, B_LOG, B_EXPK, B_EXP, B_SHIFT, B_ALT
	} bstate_t;

	bstate_t              state_q;
	logic [30:0]          m_q;
	logic [23:0]          frac_q;
	logic [4:0]           exp_q;
	logic [LOG_W-1:0]     lp_q;
	logic [ITER_W-1:0]    cnt_q;
	logic                 phase_q;
	logic [16:0]          sea_q;
	logic                 neg_q;
	logic signed [5:0]    n_q;
	logic [23:0]          f_q;
	logic [31:0]          y_q;
	logic [MUL_A_W-1:0]   opa_q;
	logic signed [17:0]   alt_q;
	logic                 done_q;

	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic [MUL_P_W-1:0]   prod;

	logic [31:0]          sq;
	logic [LOG_W-1:0]     lv;
	logic signed [29:0]   d;
	logic [27:0]          q;
	logic [27:0]          nq;
	logic [32:0]          yn;
	logic [35:0]          big_y;
	logic [52:0]          asum;
	logic [22:0]          aq;
	logic [4:0]           p_top;
	logic [30:0]          p_norm;
	logic [4:0]           s_top;
	logic [30:0]          s_norm;
	logic [ROOT_W-1:0]    root;

	function automatic logic [4:0] top_bit(input logic [16:0] v);
		logic [4:0] e;
		e = '0;
		for (int k = 1; k < 17; k++) begin
			if (v[k]) e = 5'(k);
		end
		return e;
	endfunction

	pat_mul u_mul (.a(mul_a), .b(mul_b), .p(prod));

	always_comb begin
		p_top  = top_bit(req.pressure[16:0]);
		p_norm = 31'(req.pressure[16:0]) << (5'd30 - p_top);
		s_top  = top_bit(sea_q);
		s_norm = 31'(sea_q) << (5'd30 - s_top);
		root   = ROOTS[cnt_q*ROOT_W +: ROOT_W];
		unique case (state_q)
			B_LOG:   begin mul_a = MUL_A_W'(m_q);  mul_b = m_q; end
			B_EXPK:  begin mul_a = opa_q;          mul_b = MUL_B_W'(EXP_K); end
			B_EXP:   begin mul_a = MUL_A_W'(y_q);  mul_b = root; end
			B_ALT:   begin mul_a = opa_q;          mul_b = MUL_B_W'(ALT_SCALE); end
			default: begin mul_a = '0;             mul_b = '0; end
		endcase
		sq    = prod[61:30];
		lv    = {exp_q, frac_q[22:0], sq[31]};
		d     = signed'({1'b0, lp_q}) - signed'({1'b0, lv});
		q     = 28'((prod[56:0] + 57'(1 << 29)) >> 30);
		nq    = 28'(0) - q;
		yn    = 33'((prod[62:0] + 63'(1 << 29)) >> 30);
		big_y = (n_q >= 0) ? (36'(y_q) << n_q[3:0]) : (36'(y_q) >> 6'(-n_q));
		asum  = {1'b0, prod[51:0]} + 53'(1 << 29);
		aq    = asum[52:30];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (req.start) begin
						sea_q <= (req.sea_level == 17'd0) ? 17'd1 : req.sea_level;
						if (req.pressure[17] || req.pressure == 18'sd0) begin
							alt_q  <= 18'(ALT_SCALE);
							done_q <= 1'b1;
						end else begin
							m_q     <= p_norm;
							exp_q   <= p_top;
							frac_q  <= '0;
							cnt_q   <= '0;
							phase_q <= 1'b0;
							state_q <= B_LOG;
						end
					end
				end
				B_LOG: begin
					// one squaring per fraction bit
					m_q    <= sq[31] ? sq[31:1] : sq[30:0];
					frac_q <= {frac_q[22:0], sq[31]};
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == LAST_ITER) begin
						cnt_q <= '0;
						if (!phase_q) begin
							lp_q    <= lv;
							m_q     <= s_norm;
							exp_q   <= s_top;
							frac_q  <= '0;
							phase_q <= 1'b1;
						end else begin
							neg_q   <= d[29];
							opa_q   <= MUL_A_W'(d[29] ? 30'(-d) : 30'(d));
							state_q <= B_EXPK;
						end
					end
				end
				B_EXPK: begin
					if (neg_q) begin
						f_q <= nq[23:0];
						n_q <= -(6'(q[27:24]) + 6'(q[23:0] != 24'd0));
					end else begin
						f_q <= q[23:0];
						n_q <= (q[27:24] > 4'd8) ? 6'sd8 : 6'(q[27:24]);
					end
					y_q     <= 32'd1 << 30;
					cnt_q   <= '0;
					state_q <= B_EXP;
				end
				B_EXP: begin
					if (f_q[23]) y_q <= yn[31:0];
					f_q   <= {f_q[22:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_ITER) state_q <= B_SHIFT;
				end
				B_SHIFT: begin
					neg_q   <= big_y > 36'(1 << 30);
					opa_q   <= (big_y > 36'(1 << 30)) ? big_y - 36'(1 << 30)
						: 36'(1 << 30) - big_y;
					state_q <= B_ALT;
				end
				B_ALT: begin
					if (neg_q) begin
						alt_q <= (aq > 23'd65536) ? -18'sd65536 : 18'(-aq);
					end else begin
						alt_q <= (aq > 23'd131071) ? 18'sd131071 : 18'(aq);
					end
					done_q  <= 1'b1;
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign rsp.done     = done_q;
	assign rsp.altitude = alt_q;

endmodule

/* sv/pressure_altitude_trend_core.sv */
// ----------------------------------------------------------------------------
// pressure_altitude_trend_core
// altitude from gps or barometric samples with a saturating trend direction
// ----------------------------------------------------------------------------
// a gps beat (tuser 0) is passed through as the altitude and its result is
// ready the cycle after it is taken; a pressure beat (tuser 1) goes through
// the barometric sequencer, which reuses one multiplier for 24 squarings of
// log2(p), 24 of log2(sea level), one exponent multiply, 24 root products
// and one scale multiply before a pressure beat raises m_tvalid (a zero or
// negative pressure skips them); the input stays not ready while the
// sequencer runs
module pressure_altitude_trend_core (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [17:0] sample_value
	input  logic        s_tuser,   // [0] sample_source
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [17:0] altitude_m, [19:18] direction
	// apb config
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pat_pkg::*;

	typedef enum logic {T_IDLE, T_BARO} tstate_t;

	tstate_t            state_q;
	logic [16:0]        slp_q;
	logic [14:0]        tmc_q;
	logic signed [15:0] omc_q;
	logic signed [17:0] last_q;
	logic               have_prev_q;
	logic signed [15:0] up_q;
	logic signed [15:0] down_q;
	logic               m_tvalid_q;
	logic [23:0]        m_tdata_q;

	baro_req_t          breq;
	baro_rsp_t          brsp;

	logic               in_beat;
	logic               upd_en;
	logic signed [17:0] upd_alt;
	logic signed [15:0] up_nx;
	logic signed [15:0] down_nx;
	logic signed [15:0] up_inc, up_dec, down_inc, down_dec;
	dir_t               dir_nx;
	reg_idx_t           ridx;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[3:2]);

	// register readback
	always_comb begin
		unique case (ridx)
			REG_SLP:  prdata = 32'(slp_q);
			REG_TMC:  prdata = 32'(tmc_q);
			REG_OMC:  prdata = 32'(unsigned'(omc_q));
			default:  prdata = '0;
		endcase
	end

	// new beat only when idle and the result slot is free or draining this cycle
	assign s_tready = (state_q == T_IDLE) && (!m_tvalid_q || m_tready);
	assign in_beat  = s_tvalid && s_tready;

	assign breq.start     = in_beat && s_tuser;
	assign breq.pressure  = signed'(s_tdata[17:0]);
	assign breq.sea_level = slp_q;

	pat_baro u_baro (.clk(clk), .arst_n(arst_n), .req(breq), .rsp(brsp));

	// trend update, shared by both sources
	always_comb begin
		upd_en  = (in_beat && !s_tuser) || (state_q == T_BARO && brsp.done);
		upd_alt = (state_q == T_BARO) ? brsp.altitude : signed'(s_tdata[17:0]);
		// saturating steps
		up_inc   = (up_q == 16'sh7fff) ? up_q : up_q + 16'sd1;
		up_dec   = (up_q == -16'sh8000) ? up_q : up_q - 16'sd1;
		down_inc = (down_q == 16'sh7fff) ? down_q : down_q + 16'sd1;
		down_dec = (down_q == -16'sh8000) ? down_q : down_q - 16'sd1;
		up_nx   = up_q;
		down_nx = down_q;
		if (have_prev_q) begin
			if (upd_alt > last_q) begin
				up_nx   = up_inc;
				down_nx = down_dec;
			end else begin
				up_nx   = up_dec;
				down_nx = down_inc;
			end
		end
		priority if (up_nx >= signed'({1'b0, tmc_q}) && down_nx <= omc_q) dir_nx = DIR_ASC;
		else if (down_nx >= signed'({1'b0, tmc_q}) && up_nx <= omc_q) dir_nx = DIR_DESC;
		else dir_nx = DIR_STATIC;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			slp_q       <= SLP_RESET;
			tmc_q       <= TMC_RESET;
			omc_q       <= OMC_RESET;
			last_q      <= '0;
			have_prev_q <= 1'b0;
			up_q        <= '0;
			down_q      <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			// config write on the access cycle
			if (psel && penable && pwrite && pready) begin
				unique case (ridx)
					REG_SLP:  slp_q <= pwdata[16:0];
					REG_TMC:  tmc_q <= pwdata[14:0];
					REG_OMC:  omc_q <= signed'(pwdata[15:0]);
					default:  ;
				endcase
			end
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				T_IDLE:  if (in_beat && s_tuser) state_q <= T_BARO;
				T_BARO:  if (brsp.done) state_q <= T_IDLE;
				default: state_q <= T_IDLE;
			endcase
			if (upd_en) begin
				last_q      <= upd_alt;
				have_prev_q <= 1'b1;
				up_q        <= up_nx;
				down_q      <= down_nx;
				m_tvalid_q  <= 1'b1;
				m_tdata_q   <= {4'b0, dir_nx, upd_alt};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* sv/pat_checker.sv */
// ----------------------------------------------------------------------------
// pat_checker
// port level checks of the altitude trend core
// ----------------------------------------------------------------------------
module pat_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        pready
);
	import pat_pkg::*;

	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[19:18] != DIR_BAD))
		else $error("direction code out of range");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while result blocked");

	a_baro_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser) |=> !s_tready)
		else $error("pressure beat did not hold off input");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind pressure_altitude_trend_core pat_checker u_pat_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .pready(pready)
);

/* tb/sv/pressure_altitude_trend_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_altitude_trend_core_tb
// self-checking bench for the altitude trend core
// ----------------------------------------------------------------------------
// beats go in on the slave stream with random gaps and come back on the
// master stream under random back-pressure. Each accepted beat is run through
// a bit-true model of the fixed-point barometric formula and the saturating
// trend counters, and every result beat is checked against the oldest
// prediction. Registers are rewritten over apb between phases while idle.
// ----------------------------------------------------------------------------
module pressure_altitude_trend_core_tb;
	import pat_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 100;

	typedef struct {
		logic signed [17:0] alt;
		dir_t               dir;
	} alt_dir_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [17:0] sample_value
	logic        s_tuser;   // [0] sample_source
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [17:0] altitude_m, [19:18] direction
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// model copy of registers and trend state
	logic [16:0]        mdl_sea_level;
	logic [14:0]        mdl_trend_min;
	logic signed [15:0] mdl_opp_max;
	logic signed [17:0] mdl_last_alt;
	logic               mdl_have_prev;
	int                 mdl_up;
	int                 mdl_down;
	longint unsigned    root_q30 [1:24];

	alt_dir_t pending_results [$];
	int       mismatches;
	int       idle_cycles;
	bit       no_gaps;

	pressure_altitude_trend_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// floor square root, one result bit at a time from the top
	function automatic longint unsigned floor_sqrt(input longint unsigned x);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= x) r = t;
		end
		return r;
	endfunction

	// log2 in q.24: top bit index plus 24 fraction bits by squaring
	function automatic longint log2_q24(input longint unsigned v);
		int              top;
		longint unsigned m;
		longint unsigned frac;
		top = 0;
		frac = 0;
		for (int k = 1; k < 32; k++) begin
			if ((v >> k) != 0) top = k;
		end
		m = v << (30 - top);
		for (int i = 1; i <= 24; i++) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				frac = frac | (64'd1 << (24 - i));
			end
		end
		return longint'((64'(unsigned'(top)) << 24) | frac);
	endfunction

	function automatic logic signed [17:0] pressure_to_alt(input logic signed [17:0] p);
		longint unsigned slp;
		longint          d;
		longint          e;
		longint          n;
		longint          a;
		longint unsigned mag;
		longint unsigned q;
		longint unsigned f;
		longint unsigned y;
		longint unsigned big_y;
		slp = (mdl_sea_level == 0) ? 1 : mdl_sea_level;
		if (p <= 0) return 18'sd44330;
		d = log2_q24(64'(p)) - log2_q24(slp);
		mag = (d < 0) ? unsigned'(-d) : unsigned'(d);
		q = (mag * 204322332 + (64'd1 << 29)) >> 30;
		e = (d < 0) ? -longint'(q) : longint'(q);
		// arithmetic shift gives the floor for negative exponents too
		n = e >>> 24;
		f = unsigned'(e - (n <<< 24));
		y = 64'd1 << 30;
		for (int i = 1; i <= 24; i++) begin
			if ((f >> (24 - i)) & 1) y = (y * root_q30[i] + (64'd1 << 29)) >> 30;
		end
		if (n > 8) n = 8;
		if (n < -31) n = -31;
		big_y = (n >= 0) ? (y << n) : (y >> (-n));
		a = 64'sd44330 * ((64'sd1 <<< 30) - longint'(big_y));
		mag = (a < 0) ? unsigned'(-a) : unsigned'(a);
		q = (mag + (64'd1 << 29)) >> 30;
		a = (a < 0) ? -longint'(q) : longint'(q);
		if (a < -65536) a = -65536;
		if (a > 131071) a = 131071;
		return a[17:0];
	endfunction

	function automatic int clamp16(input int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// advance the trend model by one accepted sample
	function automatic alt_dir_t predict_altitude_trend(input logic signed [17:0] value,
			input logic source);
		alt_dir_t res;
		res.alt = source ? pressure_to_alt(value) : value;
		if (mdl_have_prev) begin
			if (res.alt > mdl_last_alt) begin
				mdl_up = clamp16(mdl_up + 1);
				mdl_down = clamp16(mdl_down - 1);
			end else begin
				mdl_up = clamp16(mdl_up - 1);
				mdl_down = clamp16(mdl_down + 1);
			end
		end
		mdl_last_alt = res.alt;
		mdl_have_prev = 1'b1;
		if (mdl_up >= int'(mdl_trend_min) && mdl_down <= int'(mdl_opp_max))
			res.dir = DIR_ASC;
		else if (mdl_down >= int'(mdl_trend_min) && mdl_up <= int'(mdl_opp_max))
			res.dir = DIR_DESC;
		else
			res.dir = DIR_STATIC;
		return res;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(0, 2);
		if (r < 95) return $urandom_range(3, 10);
		return $urandom_range(20, 150);
	endfunction

	// result checker and receiver back-pressure
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
			idle_cycles <= 0;
		end else begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: %h", m_tdata);
				end else begin
					alt_dir_t exp_res;
					exp_res = pending_results.pop_front();
					if (m_tdata[17:0] !== exp_res.alt || m_tdata[19:18] !== exp_res.dir) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: alt exp %0d got %0d, dir exp %0d got %0d",
								exp_res.alt, $signed(m_tdata[17:0]), exp_res.dir,
								m_tdata[19:18]);
					end
				end
			end
			// pick the next ready level
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				stall_left <= gap_len();
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// nothing moving for too long means the core is stuck
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// valid stays high into the next beat when there is no gap
	task automatic send_sample(input logic signed [17:0] value, input logic source);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, value};
		s_tuser <= source;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(predict_altitude_trend(value, source));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 4'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SLP: mdl_sea_level = value[16:0];
			REG_TMC: mdl_trend_min = value[14:0];
			REG_OMC: mdl_opp_max = value[15:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [31:0] slp, input logic [31:0] tmc,
			input logic [31:0] omc);
		wait_idle();
		write_reg(REG_SLP, slp);
		write_reg(REG_TMC, tmc);
		write_reg(REG_OMC, omc);
	endtask

	// field extremes, pressure corner cases, unusual sea level settings
	task automatic test_directed();
		send_sample(18'sd1000, 1'b0);   // first sample, no comparison
		send_sample(-18'sd65536, 1'b0);
		send_sample(18'sd131071, 1'b0);
		send_sample(18'sd131071, 1'b0); // equal counts as not above
		send_sample(18'sd0, 1'b1);      // zero pressure
		send_sample(-18'sd1, 1'b1);
		send_sample(-18'sd65536, 1'b1);
		send_sample(18'sd1, 1'b1);      // lowest positive pressure
		send_sample(18'sd131071, 1'b1);
		send_sample(18'sd101325, 1'b1);
		send_sample(18'sd80000, 1'b1);
		send_sample(18'sd2, 1'b0);
		set_regs(32'd0, 32'd0, 32'h0000_8000);
		send_sample(18'sd1, 1'b1);      // sea level treated as one
		send_sample(18'sd100, 1'b1);
		send_sample(18'sd131071, 1'b1);
		set_regs(32'h0001_ffff, 32'h7fff, 32'h7fff);
		send_sample(18'sd1, 1'b1);
		send_sample(18'sd65536, 1'b1);
		send_sample(18'sd120000, 1'b1);
		set_regs(32'd120000, 32'd20, 32'd10);
		send_sample(18'sd80000, 1'b1);
		send_sample(18'sd131071, 1'b1);
	endtask

	// long monotonic runs in both directions, beats back to back
	task automatic test_long_runs();
		set_regs(32'd101325, 32'd20, 32'd10);
		no_gaps = 1'b1;
		for (int k = 0; k < 40; k++)
			send_sample(18'(-65536 + k), 1'b0);
		for (int k = 0; k < 60; k++)
			send_sample(18'sd0, 1'b0);
		no_gaps = 1'b0;
	endtask

	// random walks of altitude or pressure with some noise beats
	task automatic random_phase(input int count);
		int                 walk;
		int                 step_dir;
		int                 run_len;
		logic               src;
		logic signed [17:0] v;
		walk = $urandom_range(0, 3000);
		step_dir = 1;
		run_len = 0;
		src = 1'b0;
		for (int k = 0; k < count; k++) begin
			if (run_len == 0) begin
				run_len = $urandom_range(5, 40);
				step_dir = ($urandom_range(0, 1) == 1) ? 1 : -1;
				src = $urandom_range(0, 1);
				walk = src ? $urandom_range(85000, 115000) : $urandom_range(0, 5000);
			end
			run_len--;
			if ($urandom_range(0, 9) < 2) begin
				v = 18'($urandom);
				send_sample(v, $urandom_range(0, 1));
			end else begin
				// pressure falls as altitude rises
				walk = walk + (src ? -step_dir : step_dir) * int'($urandom_range(0, 60));
				send_sample(18'(walk), src);
			end
		end
	endtask

	task automatic test_random();
		set_regs(32'd101325, 32'd20, 32'd10);
		random_phase(130);
		set_regs(32'd80000, 32'd0, 32'hffff_8000);
		random_phase(130);
		set_regs(32'd120000, 32'd5, 32'd2);
		random_phase(130);
		set_regs($urandom, $urandom, $urandom);
		random_phase(130);
		set_regs($urandom_range(80000, 120000), $urandom_range(0, 30), $urandom_range(0, 15));
		random_phase(130);
		set_regs($urandom_range(80000, 120000), 32'd3, 32'hffff_fffe);
		random_phase(130);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatches = 0;
		no_gaps = 1'b0;
		mdl_sea_level = SLP_RESET;
		mdl_trend_min = TMC_RESET;
		mdl_opp_max = OMC_RESET;
		mdl_last_alt = '0;
		mdl_have_prev = 1'b0;
		mdl_up = 0;
		mdl_down = 0;
		// roots 2^(2^-i) in q1.30
		root_q30[1] = floor_sqrt((64'd2 << 30) << 30);
		for (int i = 2; i <= 24; i++) root_q30[i] = floor_sqrt(root_q30[i-1] << 30);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_long_runs();
		test_random();
		wait_idle();
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
